>>> rtl/tclru_pkg.sv
// Shared types and constants for the tile cache LRU policy block.
// Used by tclru_ctrl, tclru_dp and tile_cache_lru_policy; depends on nothing.
package tclru_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int COORD_BITS_DEF = 16;

  // Configuration port.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int MAX_W  = 7;
  localparam logic [0:0]       REG_MAX_ENTRIES = 1'b0;
  localparam logic [MAX_W-1:0] MAX_ENTRIES_RST = 7'd64;

  // Item actions.
  localparam int ACT_W = 2;
  localparam logic [ACT_W-1:0] ACT_REQUEST = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PROBE   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_INVAL   = 2'd2;

  // What follows the lookup scan.
  typedef enum logic [1:0] {
    PLAN_NONE,
    PLAN_WRITE,
    PLAN_TOUCH
  } plan_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic touch;
  } dp_cmd_t;

  typedef struct packed {
    logic  more;
    plan_t plan;
  } dp_stat_t;

endpackage

>>> rtl/tclru_ctrl.sv
// Sequencer for the tile cache LRU policy: lookup pass, decision, recency pass.
// Depends on tclru_pkg for the command and status structs.
module tclru_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output tclru_pkg::dp_cmd_t cmd,
  input  tclru_pkg::dp_stat_t stat
);
  import tclru_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_TOUCH,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_SCAN;
      ST_SCAN:   if (!stat.more) state_next = ST_DECIDE;
      ST_DECIDE: state_next = (stat.plan == PLAN_TOUCH) ? ST_TOUCH : ST_DONE;
      // The write for the last entry read lands in the cycle that leaves here.
      ST_TOUCH:  if (!stat.more) state_next = ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load   = (state == ST_IDLE) && start;
    cmd.scan   = (state == ST_SCAN) && stat.more;
    cmd.decide = (state == ST_DECIDE);
    cmd.touch  = (state == ST_TOUCH) && stat.more;
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state_next == ST_DONE);
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe outside an item");
  a_start_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("went busy without an accepted item");

endmodule

>>> rtl/tclru_dp.sv
// Datapath of the tile cache LRU policy: slot memory, scan pipeline, fill count,
// recency update and result registers. Depends on tclru_pkg.
module tclru_dp #(
  parameter int DEPTH      = tclru_pkg::DEPTH_DEF,
  parameter int COORD_BITS = tclru_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tclru_pkg::dp_cmd_t            cmd,
  output tclru_pkg::dp_stat_t           stat,
  input  logic [tclru_pkg::MAX_W-1:0]   max_entries,
  input  logic [tclru_pkg::ACT_W-1:0]   action,
  input  logic [COORD_BITS-1:0]         tile_col,
  input  logic [COORD_BITS-1:0]         tile_row,
  output logic                          hit,
  output logic                          needs_paint,
  output logic [$clog2(DEPTH)-1:0]      slot,
  output logic                          evicted,
  output logic [COORD_BITS-1:0]         evicted_col,
  output logic [COORD_BITS-1:0]         evicted_row,
  output logic                          present_fresh
);
  import tclru_pkg::*;

  localparam int SW = $clog2(DEPTH);
  localparam int UW = $clog2(DEPTH + 1);
  localparam int AW = SW;
  localparam int WW = 2 * COORD_BITS + 1 + AW;
  localparam int LW = (UW > MAX_W) ? UW : MAX_W;

  // Entry word: column, row, stale flag, recency rank (0 is least recent).
  logic [WW-1:0] mem [DEPTH];

  logic [ACT_W-1:0]      act_q;
  logic [COORD_BITS-1:0] col_q;
  logic [COORD_BITS-1:0] row_q;
  logic [UW-1:0]         idx;
  logic [UW-1:0]         used;
  logic                  rd_vld_q;
  logic                  rd_touch_q;
  logic [SW-1:0]         rd_idx_q;
  logic [WW-1:0]         rd_q;

  logic                  found;
  logic [SW-1:0]         f_idx;
  logic                  f_stale;
  logic [AW-1:0]         f_age;
  logic [SW-1:0]         lru_idx;
  logic [COORD_BITS-1:0] lru_col;
  logic [COORD_BITS-1:0] lru_row;
  logic [SW-1:0]         tgt;
  logic [AW-1:0]         tgt_r;

  logic [COORD_BITS-1:0] rd_col;
  logic [COORD_BITS-1:0] rd_row;
  logic                  rd_stale;
  logic [AW-1:0]         rd_age;
  logic [LW-1:0]         me_w;
  logic [LW-1:0]         lim;
  logic                  full;
  plan_t                 plan;

  logic                  wr_en;
  logic [SW-1:0]         wr_addr;
  logic [WW-1:0]         wr_data;
  logic [AW-1:0]         age_new;

  logic                  hit_n;
  logic                  paint_n;
  logic [SW-1:0]         slot_n;
  logic                  ev_n;
  logic [COORD_BITS-1:0] ecol_n;
  logic [COORD_BITS-1:0] erow_n;
  logic                  fresh_n;

  assign rd_col   = rd_q[WW-1 -: COORD_BITS];
  assign rd_row   = rd_q[AW+COORD_BITS -: COORD_BITS];
  assign rd_stale = rd_q[AW];
  assign rd_age   = rd_q[AW-1:0];

  // A limit of zero or above the depth means the whole store.
  always_comb begin
    me_w = LW'(max_entries);
    if (me_w == '0 || me_w > LW'(DEPTH)) begin
      lim = LW'(DEPTH);
    end else begin
      lim = me_w;
    end
    full = (LW'(used) >= lim);
  end

  always_comb begin
    plan = PLAN_NONE;
    case (act_q)
      ACT_REQUEST: plan = (found || full) ? PLAN_TOUCH : PLAN_WRITE;
      ACT_INVAL:   plan = found ? PLAN_WRITE : PLAN_NONE;
      default:     plan = PLAN_NONE;
    endcase
  end

  assign stat.more = (idx < used);
  assign stat.plan = plan;

  // Single write port: a fill or an invalidate at decision time, or the
  // rewrite of each entry in the cycle after it is read in the recency pass.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    age_new = rd_age;
    if (rd_age > tgt_r) begin
      age_new = rd_age - 1'b1;
    end
    if (cmd.decide && plan == PLAN_WRITE) begin
      wr_en = 1'b1;
      if (act_q == ACT_REQUEST) begin
        wr_addr = used[SW-1:0];
        wr_data = {col_q, row_q, 1'b0, used[AW-1:0]};
      end else begin
        wr_addr = f_idx;
        wr_data = {col_q, row_q, 1'b1, f_age};
      end
    end else if (rd_vld_q && rd_touch_q) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx_q;
      if (rd_idx_q == tgt) begin
        wr_data = {col_q, row_q, 1'b0, AW'(used - 1'b1)};
      end else begin
        wr_data = {rd_col, rd_row, rd_stale, age_new};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan || cmd.touch) begin
      rd_q <= mem[idx[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd.scan || cmd.touch;
      if (cmd.decide && plan == PLAN_WRITE && act_q == ACT_REQUEST) begin
        used <= used + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_touch_q <= cmd.touch;
    rd_idx_q   <= idx[SW-1:0];
    if (cmd.load || cmd.decide) begin
      idx <= '0;
    end else if (cmd.scan || cmd.touch) begin
      idx <= idx + 1'b1;
    end
    if (cmd.load) begin
      act_q   <= action;
      col_q   <= tile_col;
      row_q   <= tile_row;
      found   <= 1'b0;
      lru_idx <= '0;
    end else if (rd_vld_q && !rd_touch_q) begin
      // The first matching slot wins; ranks are unique, so one slot has rank 0.
      if (!found && rd_col == col_q && rd_row == row_q) begin
        found   <= 1'b1;
        f_idx   <= rd_idx_q;
        f_stale <= rd_stale;
        f_age   <= rd_age;
      end
      if (rd_age == '0) begin
        lru_idx <= rd_idx_q;
        lru_col <= rd_col;
        lru_row <= rd_row;
      end
    end
    if (cmd.decide) begin
      tgt   <= found ? f_idx : lru_idx;
      tgt_r <= found ? f_age : '0;
    end
  end

  always_comb begin
    hit_n   = 1'b0;
    paint_n = 1'b0;
    slot_n  = '0;
    ev_n    = 1'b0;
    ecol_n  = '0;
    erow_n  = '0;
    fresh_n = 1'b0;
    case (act_q)
      ACT_REQUEST: begin
        if (found) begin
          hit_n   = 1'b1;
          paint_n = f_stale;
          slot_n  = f_idx;
        end else if (!full) begin
          paint_n = 1'b1;
          slot_n  = used[SW-1:0];
        end else begin
          paint_n = 1'b1;
          slot_n  = lru_idx;
          ev_n    = 1'b1;
          ecol_n  = lru_col;
          erow_n  = lru_row;
        end
      end
      ACT_PROBE: begin
        if (found) begin
          hit_n   = 1'b1;
          slot_n  = f_idx;
          fresh_n = !f_stale;
        end
      end
      ACT_INVAL: begin
        if (found) begin
          hit_n  = 1'b1;
          slot_n = f_idx;
        end
      end
      default: begin
        hit_n = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      hit           <= hit_n;
      needs_paint   <= paint_n;
      slot          <= slot_n;
      evicted       <= ev_n;
      evicted_col   <= ecol_n;
      evicted_row   <= erow_n;
      present_fresh <= fresh_n;
    end
  end

  a_used_depth: assert property (@(posedge clk) disable iff (rst) used <= UW'(DEPTH))
    else $error("fill count beyond depth");
  a_touch_in_use: assert property (@(posedge clk) disable iff (rst)
    (rd_vld_q && rd_touch_q) |-> (UW'(rd_idx_q) < used))
    else $error("recency rewrite outside the slots in use");
  a_found_in_use: assert property (@(posedge clk) disable iff (rst)
    cmd.decide && found |-> (UW'(f_idx) < used))
    else $error("match reported on a slot not in use");

endmodule

>>> rtl/tile_cache_lru_policy.sv
// Tile cache LRU policy, top level: from start to the done strobe, an item runs a
// lookup pass over the N slots in use and a decision; a request that hits or evicts
// adds a recency pass. Both passes read one slot per cycle from the slot memory's
// single read port. The next item is accepted the cycle after done.
// Synchronous reset empties the store and sets max_entries to 64; no memory clearing.
// Results are registered at the decision, valid with done, and cannot be stalled.
module tile_cache_lru_policy #(
  parameter int DEPTH      = tclru_pkg::DEPTH_DEF,
  parameter int COORD_BITS = tclru_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tclru_pkg::ADDR_W-1:0]  paddr,
  input  logic [tclru_pkg::DATA_W-1:0]  pwdata,
  output logic [tclru_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [tclru_pkg::ACT_W-1:0]   action,
  input  logic [COORD_BITS-1:0]         tile_col,
  input  logic [COORD_BITS-1:0]         tile_row,
  output logic                          done,
  output logic                          hit,
  output logic                          needs_paint,
  output logic [$clog2(DEPTH)-1:0]      slot,
  output logic                          evicted,
  output logic [COORD_BITS-1:0]         evicted_col,
  output logic [COORD_BITS-1:0]         evicted_row,
  output logic                          present_fresh
);
  import tclru_pkg::*;

  logic [MAX_W-1:0] max_entries;
  logic             reg_sel;
  dp_cmd_t          cmd;
  dp_stat_t         stat;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_MAX_ENTRIES);
  assign prdata  = reg_sel ? DATA_W'(max_entries) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MAX_ENTRIES_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_entries <= pwdata[MAX_W-1:0];
    end
  end

  tclru_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  tclru_dp #(
    .DEPTH      (DEPTH),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .max_entries   (max_entries),
    .action        (action),
    .tile_col      (tile_col),
    .tile_row      (tile_row),
    .hit           (hit),
    .needs_paint   (needs_paint),
    .slot          (slot),
    .evicted       (evicted),
    .evicted_col   (evicted_col),
    .evicted_row   (evicted_row),
    .present_fresh (present_fresh)
  );

endmodule
